FILE: hw/rtl/screen_to_hex_axial_pick_core_macros.svh
// Assertion macros for the port-level checker of the screen-to-hex pick core.
`ifndef SCREEN_TO_HEX_AXIAL_PICK_CORE_MACROS_SVH
`define SCREEN_TO_HEX_AXIAL_PICK_CORE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define S2H_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define S2H_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/s2hpick_pkg.sv
// Shared types and constants of the screen-to-hex pick core.
`default_nettype none

package s2hpick_pkg;

    // Field widths
    localparam int PIX_W     = 16;
    localparam int HEX_W     = 16;
    localparam int OFS_W     = 24;
    localparam int SQZ_W     = 24;
    localparam int SHR_W     = 21;
    localparam int ROT_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Number of register stages from input to output
    localparam int NSTG = 23;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X      = 3'd0,
        CFG_OFFSET_Y      = 3'd1,
        CFG_INV_SQUEEZE_X = 3'd2,
        CFG_INV_SQUEEZE_Y = 3'd3,
        CFG_SHEAR_HORIZ   = 3'd4,
        CFG_SHEAR_VERT    = 3'd5,
        CFG_ROT_COS       = 3'd6,
        CFG_ROT_SIN       = 3'd7
    } t_cfg_idx;

    // Reset values: unit squeeze, cos register 1/32, everything else zero
    localparam logic [SQZ_W-1:0]        SQZ_RST = 24'd65536;
    localparam logic signed [ROT_W-1:0] COS_RST = 32'sd33554432;

    // sqrt(3) in Q.26
    localparam logic signed [27:0] SQRT3_Q26 = 28'sd116235962;

    // Axial divisor 3 * 2^16
    localparam logic signed [18:0] THIRD_DEN = 19'sd196608;

    // floor(t / 3) = (t * ceil(2^25 / 3)) >> 25, exact for t < 2^25
    localparam logic [23:0] DIV3_RECIP = 24'd11184811;

endpackage

`default_nettype wire

FILE: hw/rtl/screen_to_hex_axial_pick_core.sv
// Top level of the screen-to-hex pick core: inverse view transform and axial rounding.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  point in | input     | i_valid / o_stall  | i_screen_x, i_screen_y
//  hex out  | output    | o_valid / i_stall  | o_hex_q, o_hex_r
//  config   | input     | i_cfg_we           | i_cfg_idx, i_cfg_data
//
//  One beat per cycle sustained while the output is not stalled, through a stage chain
//  (four 32x32 rotation multiplies, split shear and sqrt3 multiplies, divide by 3).
//  Reset is synchronous: it empties the pipeline and loads the register defaults.
//  A stalled output holds its beat; earlier stages keep filling any bubbles,
//  so input is taken until every stage holds a beat.
`default_nettype none

module screen_to_hex_axial_pick_core
    import s2hpick_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [PIX_W-1:0] i_screen_x,
    input  logic signed [PIX_W-1:0] i_screen_y,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [HEX_W-1:0] o_hex_q,
    output logic signed [HEX_W-1:0] o_hex_r,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    // Saturation helpers
    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        if (&v[63:39] || ~|v[63:39]) begin
            return v[39:0];
        end else if (v[63]) begin
            return {1'b1, 39'd0};
        end else begin
            return {1'b0, {39{1'b1}}};
        end
    endfunction

    function automatic logic signed [35:0] sat36(input logic signed [63:0] v);
        if (&v[63:35] || ~|v[63:35]) begin
            return v[35:0];
        end else if (v[63]) begin
            return {1'b1, 35'd0};
        end else begin
            return {1'b0, {35{1'b1}}};
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (&v[63:31] || ~|v[63:31]) begin
            return v[31:0];
        end else if (v[63]) begin
            return {1'b1, 31'd0};
        end else begin
            return {1'b0, {31{1'b1}}};
        end
    endfunction

    function automatic logic signed [HEX_W-1:0] sat16(input logic signed [63:0] v);
        if (&v[63:HEX_W-1] || ~|v[63:HEX_W-1]) begin
            return v[HEX_W-1:0];
        end else if (v[63]) begin
            return {1'b1, {(HEX_W-1){1'b0}}};
        end else begin
            return {1'b0, {(HEX_W-1){1'b1}}};
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [OFS_W-1:0] r_ofs_x, r_ofs_y;
    logic [SQZ_W-1:0]        r_isq_x, r_isq_y;
    logic signed [SHR_W-1:0] r_shr_h, r_shr_v;
    logic signed [ROT_W-1:0] r_cos, r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs_x <= '0;
            r_ofs_y <= '0;
            r_isq_x <= SQZ_RST;
            r_isq_y <= SQZ_RST;
            r_shr_h <= '0;
            r_shr_v <= '0;
            r_cos   <= COS_RST;
            r_sin   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OFFSET_X:      r_ofs_x <= i_cfg_data[OFS_W-1:0];
                CFG_OFFSET_Y:      r_ofs_y <= i_cfg_data[OFS_W-1:0];
                CFG_INV_SQUEEZE_X: r_isq_x <= i_cfg_data[SQZ_W-1:0];
                CFG_INV_SQUEEZE_Y: r_isq_y <= i_cfg_data[SQZ_W-1:0];
                CFG_SHEAR_HORIZ:   r_shr_h <= i_cfg_data[SHR_W-1:0];
                CFG_SHEAR_VERT:    r_shr_v <= i_cfg_data[SHR_W-1:0];
                CFG_ROT_COS:       r_cos   <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_SIN:       r_sin   <= i_cfg_data[ROT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when empty or when the next one does
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    assign adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
    for (genvar g = 0; g < NSTG-1; g++) begin : g_adv
        assign adv[g] = !r_vld[g] || adv[g+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~adv) | ({r_vld[NSTG-2:0], i_valid} & adv);
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // S1: translate, Q.8
    // ------------------------------------------------------------------
    logic signed [24:0] n_s1_tx, n_s1_ty;
    logic signed [24:0] r_s1_tx, r_s1_ty;

    assign n_s1_tx = {i_screen_x[PIX_W-1], i_screen_x, 8'd0} + {r_ofs_x[OFS_W-1], r_ofs_x};
    assign n_s1_ty = {i_screen_y[PIX_W-1], i_screen_y, 8'd0} + {r_ofs_y[OFS_W-1], r_ofs_y};

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_tx <= n_s1_tx;
            r_s1_ty <= n_s1_ty;
        end
    end

    // ------------------------------------------------------------------
    // S2: unsqueeze products
    // ------------------------------------------------------------------
    logic signed [49:0] n_s2_px, n_s2_py;
    logic signed [48:0] r_s2_px, r_s2_py;

    assign n_s2_px = r_s1_tx * $signed({1'b0, r_isq_x});
    assign n_s2_py = r_s1_ty * $signed({1'b0, r_isq_y});

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_px <= n_s2_px[48:0];
            r_s2_py <= n_s2_py[48:0];
        end
    end

    // ------------------------------------------------------------------
    // S3: round to Q.16 and saturate to 40 bits
    // ------------------------------------------------------------------
    logic signed [49:0] n_s3_rx, n_s3_ry;
    logic signed [39:0] r_s3_ux, r_s3_uy;

    assign n_s3_rx = (r_s2_px + 50'sd128) >>> 8;
    assign n_s3_ry = (r_s2_py + 50'sd128) >>> 8;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_ux <= sat40(64'(n_s3_rx));
            r_s3_uy <= sat40(64'(n_s3_ry));
        end
    end

    // ------------------------------------------------------------------
    // S4: vertical shear times ux, split into two partial products
    // ------------------------------------------------------------------
    logic signed [40:0] n_s4_ph;
    logic signed [41:0] n_s4_pl;
    logic signed [40:0] r_s4_ph;
    logic signed [41:0] r_s4_pl;
    logic signed [39:0] r_s4_ux, r_s4_uy;

    assign n_s4_ph = r_shr_v * $signed(r_s3_ux[39:20]);
    assign n_s4_pl = r_shr_v * $signed({1'b0, r_s3_ux[19:0]});

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_ph <= n_s4_ph;
            r_s4_pl <= n_s4_pl;
            r_s4_ux <= r_s3_ux;
            r_s4_uy <= r_s3_uy;
        end
    end

    // ------------------------------------------------------------------
    // S5: combine partials, round off 16 bits
    // ------------------------------------------------------------------
    logic signed [61:0] n_s5_sum, n_s5_sh;
    logic signed [45:0] r_s5_shv;
    logic signed [39:0] r_s5_ux, r_s5_uy;

    assign n_s5_sum = (r_s4_ph <<< 20) + r_s4_pl + 62'sd32768;
    assign n_s5_sh  = n_s5_sum >>> 16;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s5_shv <= n_s5_sh[45:0];
            r_s5_ux  <= r_s4_ux;
            r_s5_uy  <= r_s4_uy;
        end
    end

    // ------------------------------------------------------------------
    // S6: unshear y
    // ------------------------------------------------------------------
    logic signed [46:0] n_s6_dy;
    logic signed [39:0] r_s6_ux, r_s6_uy;

    assign n_s6_dy = r_s5_uy - r_s5_shv;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_s6_uy <= sat40(64'(n_s6_dy));
            r_s6_ux <= r_s5_ux;
        end
    end

    // ------------------------------------------------------------------
    // S7: horizontal shear times new uy, partial products
    // ------------------------------------------------------------------
    logic signed [40:0] n_s7_ph;
    logic signed [41:0] n_s7_pl;
    logic signed [40:0] r_s7_ph;
    logic signed [41:0] r_s7_pl;
    logic signed [39:0] r_s7_ux, r_s7_uy;

    assign n_s7_ph = r_shr_h * $signed(r_s6_uy[39:20]);
    assign n_s7_pl = r_shr_h * $signed({1'b0, r_s6_uy[19:0]});

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_s7_ph <= n_s7_ph;
            r_s7_pl <= n_s7_pl;
            r_s7_ux <= r_s6_ux;
            r_s7_uy <= r_s6_uy;
        end
    end

    // ------------------------------------------------------------------
    // S8: combine partials, round off 16 bits
    // ------------------------------------------------------------------
    logic signed [61:0] n_s8_sum, n_s8_sh;
    logic signed [45:0] r_s8_shh;
    logic signed [39:0] r_s8_ux, r_s8_uy;

    assign n_s8_sum = (r_s7_ph <<< 20) + r_s7_pl + 62'sd32768;
    assign n_s8_sh  = n_s8_sum >>> 16;

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_s8_shh <= n_s8_sh[45:0];
            r_s8_ux  <= r_s7_ux;
            r_s8_uy  <= r_s7_uy;
        end
    end

    // ------------------------------------------------------------------
    // S9: unshear x
    // ------------------------------------------------------------------
    logic signed [46:0] n_s9_dx;
    logic signed [39:0] r_s9_ux, r_s9_uy;

    assign n_s9_dx = r_s8_ux - r_s8_shh;

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r_s9_ux <= sat40(64'(n_s9_dx));
            r_s9_uy <= r_s8_uy;
        end
    end

    // ------------------------------------------------------------------
    // S10: back to Q.8, saturate to 32 bits
    // ------------------------------------------------------------------
    logic signed [40:0] n_s10_x, n_s10_y;
    logic signed [31:0] r_s10_xr, r_s10_yr;

    assign n_s10_x = (r_s9_ux + 41'sd128) >>> 8;
    assign n_s10_y = (r_s9_uy + 41'sd128) >>> 8;

    always_ff @(posedge i_clk) begin
        if (adv[9]) begin
            r_s10_xr <= sat32(64'(n_s10_x));
            r_s10_yr <= sat32(64'(n_s10_y));
        end
    end

    // ------------------------------------------------------------------
    // S11: rotation products
    // ------------------------------------------------------------------
    logic signed [63:0] n_s11_xc, n_s11_ys, n_s11_yc, n_s11_xs;
    logic signed [63:0] r_s11_xc, r_s11_ys, r_s11_yc, r_s11_xs;

    assign n_s11_xc = r_s10_xr * r_cos;
    assign n_s11_ys = r_s10_yr * r_sin;
    assign n_s11_yc = r_s10_yr * r_cos;
    assign n_s11_xs = r_s10_xr * r_sin;

    always_ff @(posedge i_clk) begin
        if (adv[10]) begin
            r_s11_xc <= n_s11_xc;
            r_s11_ys <= n_s11_ys;
            r_s11_yc <= n_s11_yc;
            r_s11_xs <= n_s11_xs;
        end
    end

    // ------------------------------------------------------------------
    // S12: round each product to Q.16
    // ------------------------------------------------------------------
    logic signed [64:0] n_s12_xc, n_s12_ys, n_s12_yc, n_s12_xs;
    logic signed [42:0] r_s12_xc, r_s12_ys, r_s12_yc, r_s12_xs;

    assign n_s12_xc = (r_s11_xc + 65'sd2097152) >>> 22;
    assign n_s12_ys = (r_s11_ys + 65'sd2097152) >>> 22;
    assign n_s12_yc = (r_s11_yc + 65'sd2097152) >>> 22;
    assign n_s12_xs = (r_s11_xs + 65'sd2097152) >>> 22;

    always_ff @(posedge i_clk) begin
        if (adv[11]) begin
            r_s12_xc <= n_s12_xc[42:0];
            r_s12_ys <= n_s12_ys[42:0];
            r_s12_yc <= n_s12_yc[42:0];
            r_s12_xs <= n_s12_xs[42:0];
        end
    end

    // ------------------------------------------------------------------
    // S13: hex-space X and Y, saturate to 36 bits
    // ------------------------------------------------------------------
    logic signed [43:0] n_s13_x, n_s13_y;
    logic signed [35:0] r_s13_x, r_s13_y;

    assign n_s13_x = r_s12_xc + r_s12_ys;
    assign n_s13_y = r_s12_yc - r_s12_xs;

    always_ff @(posedge i_clk) begin
        if (adv[12]) begin
            r_s13_x <= sat36(64'(n_s13_x));
            r_s13_y <= sat36(64'(n_s13_y));
        end
    end

    // ------------------------------------------------------------------
    // S14: X times sqrt3, split into two partial products
    // ------------------------------------------------------------------
    logic signed [45:0] n_s14_ph;
    logic signed [46:0] n_s14_pl;
    logic signed [45:0] r_s14_ph;
    logic signed [46:0] r_s14_pl;
    logic signed [35:0] r_s14_y;

    assign n_s14_ph = $signed(r_s13_x[35:18]) * SQRT3_Q26;
    assign n_s14_pl = $signed({1'b0, r_s13_x[17:0]}) * SQRT3_Q26;

    always_ff @(posedge i_clk) begin
        if (adv[13]) begin
            r_s14_ph <= n_s14_ph;
            r_s14_pl <= n_s14_pl;
            r_s14_y  <= r_s13_y;
        end
    end

    // ------------------------------------------------------------------
    // S15: combine partials, round off 26 bits
    // ------------------------------------------------------------------
    logic signed [64:0] n_s15_sum, n_s15_xk;
    logic signed [37:0] r_s15_xk;
    logic signed [35:0] r_s15_y;

    assign n_s15_sum = (r_s14_ph <<< 18) + r_s14_pl + 65'sd33554432;
    assign n_s15_xk  = n_s15_sum >>> 26;

    always_ff @(posedge i_clk) begin
        if (adv[14]) begin
            r_s15_xk <= n_s15_xk[37:0];
            r_s15_y  <= r_s14_y;
        end
    end

    // ------------------------------------------------------------------
    // S16: numerators A = X*sqrt3 - Y, B = 2Y (over 3 * 2^16)
    // ------------------------------------------------------------------
    logic signed [38:0] n_s16_a;
    logic signed [36:0] n_s16_b;
    logic signed [38:0] r_s16_a;
    logic signed [36:0] r_s16_b;

    assign n_s16_a = r_s15_xk - r_s15_y;
    assign n_s16_b = {r_s15_y, 1'b0};

    always_ff @(posedge i_clk) begin
        if (adv[15]) begin
            r_s16_a <= n_s16_a;
            r_s16_b <= n_s16_b;
        end
    end

    // ------------------------------------------------------------------
    // S17: rounding numerator (2|n| + D) / 2^17, still to be divided by 3
    // ------------------------------------------------------------------
    logic signed [40:0] n_s17_nq, n_s17_nr;
    logic [22:0]        r_s17_tq, r_s17_tr;
    logic               r_s17_sq, r_s17_sr;
    logic signed [38:0] r_s17_a;
    logic signed [36:0] r_s17_b;

    assign n_s17_nq = r_s16_a[38] ? (41'(THIRD_DEN) - (r_s16_a <<< 1))
                                  : (41'(THIRD_DEN) + (r_s16_a <<< 1));
    assign n_s17_nr = r_s16_b[36] ? (41'(THIRD_DEN) - (r_s16_b <<< 1))
                                  : (41'(THIRD_DEN) + (r_s16_b <<< 1));

    always_ff @(posedge i_clk) begin
        if (adv[16]) begin
            r_s17_tq <= n_s17_nq[39:17];
            r_s17_tr <= n_s17_nr[39:17];
            r_s17_sq <= r_s16_a[38];
            r_s17_sr <= r_s16_b[36];
            r_s17_a  <= r_s16_a;
            r_s17_b  <= r_s16_b;
        end
    end

    // ------------------------------------------------------------------
    // S18: divide by 3 through the reciprocal
    // ------------------------------------------------------------------
    logic [46:0]        n_s18_pq, n_s18_pr;
    logic [46:0]        r_s18_pq, r_s18_pr;
    logic               r_s18_sq, r_s18_sr;
    logic signed [38:0] r_s18_a;
    logic signed [36:0] r_s18_b;

    assign n_s18_pq = r_s17_tq * DIV3_RECIP;
    assign n_s18_pr = r_s17_tr * DIV3_RECIP;

    always_ff @(posedge i_clk) begin
        if (adv[17]) begin
            r_s18_pq <= n_s18_pq;
            r_s18_pr <= n_s18_pr;
            r_s18_sq <= r_s17_sq;
            r_s18_sr <= r_s17_sr;
            r_s18_a  <= r_s17_a;
            r_s18_b  <= r_s17_b;
        end
    end

    // ------------------------------------------------------------------
    // S19: signed rounded guesses qg, rg (half away from zero)
    // ------------------------------------------------------------------
    logic signed [22:0] n_s19_qm, n_s19_rm;
    logic signed [22:0] r_s19_qg, r_s19_rg;
    logic signed [38:0] r_s19_a;
    logic signed [36:0] r_s19_b;

    assign n_s19_qm = {1'b0, r_s18_pq[46:25]};
    assign n_s19_rm = {1'b0, r_s18_pr[46:25]};

    always_ff @(posedge i_clk) begin
        if (adv[18]) begin
            r_s19_qg <= r_s18_sq ? -n_s19_qm : n_s19_qm;
            r_s19_rg <= r_s18_sr ? -n_s19_rm : n_s19_rm;
            r_s19_a  <= r_s18_a;
            r_s19_b  <= r_s18_b;
        end
    end

    // ------------------------------------------------------------------
    // S20: guesses times 3
    // ------------------------------------------------------------------
    logic signed [24:0] n_s20_q3, n_s20_r3;
    logic signed [24:0] r_s20_q3, r_s20_r3;
    logic signed [22:0] r_s20_qg, r_s20_rg;
    logic signed [38:0] r_s20_a;
    logic signed [36:0] r_s20_b;

    assign n_s20_q3 = r_s19_qg + (r_s19_qg <<< 1);
    assign n_s20_r3 = r_s19_rg + (r_s19_rg <<< 1);

    always_ff @(posedge i_clk) begin
        if (adv[19]) begin
            r_s20_q3 <= n_s20_q3;
            r_s20_r3 <= n_s20_r3;
            r_s20_qg <= r_s19_qg;
            r_s20_rg <= r_s19_rg;
            r_s20_a  <= r_s19_a;
            r_s20_b  <= r_s19_b;
        end
    end

    // ------------------------------------------------------------------
    // S21: remainders, bounded by half the divisor
    // ------------------------------------------------------------------
    logic signed [41:0] n_s21_rq, n_s21_rr;
    logic signed [18:0] r_s21_rq, r_s21_rr;
    logic signed [22:0] r_s21_qg, r_s21_rg;

    assign n_s21_rq = r_s20_a - (r_s20_q3 <<< 16);
    assign n_s21_rr = r_s20_b - (r_s20_r3 <<< 16);

    always_ff @(posedge i_clk) begin
        if (adv[20]) begin
            r_s21_rq <= n_s21_rq[18:0];
            r_s21_rr <= n_s21_rr[18:0];
            r_s21_qg <= r_s20_qg;
            r_s21_rg <= r_s20_rg;
        end
    end

    // ------------------------------------------------------------------
    // S22: pick the coordinate to adjust; ties go to r
    // ------------------------------------------------------------------
    logic signed [20:0] n_s22_nq, n_s22_nr;
    logic signed [18:0] n_s22_mq, n_s22_mr;
    logic signed [20:0] r_s22_nq, r_s22_nr;
    logic               r_s22_selq;
    logic signed [22:0] r_s22_qg, r_s22_rg;

    assign n_s22_nq = (r_s21_rq <<< 1) + r_s21_rr;
    assign n_s22_nr = (r_s21_rr <<< 1) + r_s21_rq;
    assign n_s22_mq = r_s21_rq[18] ? -r_s21_rq : r_s21_rq;
    assign n_s22_mr = r_s21_rr[18] ? -r_s21_rr : r_s21_rr;

    always_ff @(posedge i_clk) begin
        if (adv[21]) begin
            r_s22_nq   <= n_s22_nq;
            r_s22_nr   <= n_s22_nr;
            r_s22_selq <= n_s22_mr < n_s22_mq;
            r_s22_qg   <= r_s21_qg;
            r_s22_rg   <= r_s21_rg;
        end
    end

    // ------------------------------------------------------------------
    // S23: apply the +-1 correction and saturate into the output register
    // ------------------------------------------------------------------
    logic signed [1:0]       n_s23_dq, n_s23_dr;
    logic signed [23:0]      n_s23_q, n_s23_r;
    logic signed [HEX_W-1:0] r_s23_q, r_s23_r;

    always_comb begin
        n_s23_dq = 2'sd0;
        n_s23_dr = 2'sd0;
        if (r_s22_selq) begin
            if (r_s22_nq >= 21'(THIRD_DEN)) begin
                n_s23_dq = 2'sd1;
            end else if (r_s22_nq <= -21'(THIRD_DEN)) begin
                n_s23_dq = -2'sd1;
            end
        end else begin
            if (r_s22_nr >= 21'(THIRD_DEN)) begin
                n_s23_dr = 2'sd1;
            end else if (r_s22_nr <= -21'(THIRD_DEN)) begin
                n_s23_dr = -2'sd1;
            end
        end
    end

    assign n_s23_q = r_s22_qg + n_s23_dq;
    assign n_s23_r = r_s22_rg + n_s23_dr;

    always_ff @(posedge i_clk) begin
        if (adv[22]) begin
            r_s23_q <= sat16(64'(n_s23_q));
            r_s23_r <= sat16(64'(n_s23_r));
        end
    end

    assign o_hex_q = r_s23_q;
    assign o_hex_r = r_s23_r;

endmodule

`default_nettype wire

FILE: hw/rtl/s2hpick_chk.sv
// Port-level checker for the screen-to-hex pick core, bound to the top level.
`default_nettype none

`include "screen_to_hex_axial_pick_core_macros.svh"

module s2hpick_chk
    import s2hpick_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [HEX_W-1:0] o_hex_q,
    input logic signed [HEX_W-1:0] o_hex_r
);

    // Held output beat keeps its payload
    `S2H_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_hex_q) && $stable(o_hex_r), "output beat changed while stalled")

    // A moving output means no stage is blocked, so input is open
    `S2H_ASSERT_IMPL(a_flow_through, !i_stall, !o_stall, "input stalled while output flows")

    // An empty output stage can never back up the pipeline
    `S2H_ASSERT_IMPL(a_empty_out_open, !o_valid, !o_stall, "input stalled with empty output stage")

    // The cycle after reset shows no result and takes input
    `S2H_ASSERT_IMPL(a_reset_empty, !$past(i_rst_n), !o_valid && !o_stall, "pipeline not empty after reset")

endmodule

bind screen_to_hex_axial_pick_core s2hpick_chk u_s2hpick_chk (.*);

`default_nettype wire

FILE: sim/tb_screen_to_hex_axial_pick_core.sv
// Self-checking testbench for the screen-to-hex pick core: random view setups, stalls, gaps.
`timescale 1ns / 100ps

module tb_screen_to_hex_axial_pick_core;
    import s2hpick_pkg::*;

    localparam longint ROOT3_Q26   = 116235962;
    localparam longint AXIAL_DEN   = 3 * 65536;
    localparam int     MAX_REPORTS = 30;
    localparam int     PTS_PER_RUN = 238;

    typedef struct packed {
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
    } screen_pt_t;

    typedef struct packed {
        logic signed [HEX_W-1:0] q;
        logic signed [HEX_W-1:0] r;
    } hex_cell_t;

    // DUT ports, inputs all known from time zero
    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_valid    = 1'b0;
    logic                    o_stall;
    logic signed [PIX_W-1:0] i_screen_x = '0;
    logic signed [PIX_W-1:0] i_screen_y = '0;
    logic                    o_valid;
    logic                    i_stall    = 1'b0;
    logic signed [HEX_W-1:0] o_hex_q;
    logic signed [HEX_W-1:0] o_hex_r;
    logic                    i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx  = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    // Shadow copy of the view registers, reset values
    logic signed [OFS_W-1:0] view_ofs_x = '0;
    logic signed [OFS_W-1:0] view_ofs_y = '0;
    logic [SQZ_W-1:0]        view_sqz_x = SQZ_W'(65536);
    logic [SQZ_W-1:0]        view_sqz_y = SQZ_W'(65536);
    logic signed [SHR_W-1:0] view_shr_h = '0;
    logic signed [SHR_W-1:0] view_shr_v = '0;
    logic signed [ROT_W-1:0] view_cos   = 32'sd33554432;
    logic signed [ROT_W-1:0] view_sin   = '0;

    screen_pt_t point_q[$];
    hex_cell_t  hex_expect_q[$];
    int         pts_outstanding = 0;
    int         err_cnt         = 0;
    int         send_idle_pct   = 0;
    int         rcv_stall_pct   = 0;

    screen_to_hex_axial_pick_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_screen_x (i_screen_x),
        .i_screen_y (i_screen_y),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_hex_q    (o_hex_q),
        .o_hex_r    (o_hex_r),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Round half up, then floor: add half an LSB and shift arithmetically
    function automatic longint rnd_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // n / d rounded half away from zero, d positive
    function automatic longint div_round(longint n, longint d);
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    // Hex cell under a screen point for the current view setup
    function automatic hex_cell_t predict_hex(logic signed [PIX_W-1:0] sx,
                                              logic signed [PIX_W-1:0] sy);
        longint    tx, ty, ux, uy, xr, yr, hx, hy, a, b;
        longint    qg, rg, rq, rr, dq, dr;
        hex_cell_t pick;
        tx = longint'(sx) * 256 + longint'(view_ofs_x);
        ty = longint'(sy) * 256 + longint'(view_ofs_y);
        ux = clip(rnd_sh(tx * longint'(view_sqz_x), 8), 40);
        uy = clip(rnd_sh(ty * longint'(view_sqz_y), 8), 40);
        // undo shear: y first, then x
        uy = clip(uy - rnd_sh(longint'(view_shr_v) * ux, 16), 40);
        ux = clip(ux - rnd_sh(longint'(view_shr_h) * uy, 16), 40);
        xr = clip(rnd_sh(ux, 8), 32);
        yr = clip(rnd_sh(uy, 8), 32);
        // rotate by the negative angle, scale folded in
        hx = clip(rnd_sh(xr * longint'(view_cos), 22) + rnd_sh(yr * longint'(view_sin), 22), 36);
        hy = clip(rnd_sh(yr * longint'(view_cos), 22) - rnd_sh(xr * longint'(view_sin), 22), 36);
        a  = rnd_sh(hx * ROOT3_Q26, 26) - hy;
        b  = 2 * hy;
        // axial rounding; on equal remainders r is adjusted
        qg = div_round(a, AXIAL_DEN);
        rg = div_round(b, AXIAL_DEN);
        rq = a - qg * AXIAL_DEN;
        rr = b - rg * AXIAL_DEN;
        dq = 0;
        dr = 0;
        if ((rr < 0 ? -rr : rr) < (rq < 0 ? -rq : rq))
            dq = div_round(2 * rq + rr, 2 * AXIAL_DEN);
        else
            dr = div_round(2 * rr + rq, 2 * AXIAL_DEN);
        pick.q = HEX_W'(clip(qg + dq, HEX_W));
        pick.r = HEX_W'(clip(rg + dr, HEX_W));
        return pick;
    endfunction

    // Register write, only issued with nothing in flight
    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_OFFSET_X:      view_ofs_x = data[OFS_W-1:0];
            CFG_OFFSET_Y:      view_ofs_y = data[OFS_W-1:0];
            CFG_INV_SQUEEZE_X: view_sqz_x = data[SQZ_W-1:0];
            CFG_INV_SQUEEZE_Y: view_sqz_y = data[SQZ_W-1:0];
            CFG_SHEAR_HORIZ:   view_shr_h = data[SHR_W-1:0];
            CFG_SHEAR_VERT:    view_shr_v = data[SHR_W-1:0];
            CFG_ROT_COS:       view_cos   = data[ROT_W-1:0];
            CFG_ROT_SIN:       view_sin   = data[ROT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_point(int x, int y);
        screen_pt_t pt;
        pt.x = PIX_W'(x);
        pt.y = PIX_W'(y);
        point_q = {point_q, pt};
        pts_outstanding++;
    endtask

    task automatic wait_drained();
        while (pts_outstanding != 0)
            @(posedge i_clk);
    endtask

    // Point driver: hold a beat until taken, random gaps between beats
    always @(posedge i_clk) begin : point_drive
        screen_pt_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                hex_expect_q = {hex_expect_q, predict_hex(i_screen_x, i_screen_y)};
            if (!i_valid || !o_stall) begin
                if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = point_q.pop_front();
                    i_screen_x <= nxt.x;
                    i_screen_y <= nxt.y;
                    i_valid    <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Hex monitor: check each taken beat, random back-pressure
    always @(posedge i_clk) begin : hex_check
        hex_cell_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (hex_expect_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected hex beat q=%0d r=%0d",
                                 $time, o_hex_q, o_hex_r);
                end else begin
                    want = hex_expect_q.pop_front();
                    pts_outstanding--;
                    if (o_hex_q !== want.q) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: hex_q mismatch expected %0d actual %0d",
                                     $time, want.q, o_hex_q);
                    end
                    if (o_hex_r !== want.r) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: hex_r mismatch expected %0d actual %0d",
                                     $time, want.r, o_hex_r);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // Stimulus sequence
    initial begin : stim
        logic [CFG_W-1:0] w;
        bit               wide;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset view, 32 px hexes: center tie, corners of the field range
        add_point(0, 0);
        add_point(32767, 32767);
        add_point(-32768, -32768);
        add_point(32767, -32768);
        add_point(-32768, 32767);
        add_point(-1, -1);
        add_point(16, -28);
        add_point(27, 16);
        wait_drained();

        // x axis collapsed by a zero squeeze reciprocal
        cfg_write(CFG_INV_SQUEEZE_X, '0);
        add_point(1234, -77);
        add_point(-32768, 32767);
        add_point(32767, 0);
        wait_drained();

        // zero rotation registers pick hex (0,0) everywhere
        cfg_write(CFG_ROT_COS, '0);
        cfg_write(CFG_ROT_SIN, '0);
        add_point(32767, 32767);
        add_point(-5, 9);
        add_point(-32768, -32768);
        wait_drained();

        // register extremes one way: intermediates and results saturate
        cfg_write(CFG_OFFSET_X, 32'h007F_FFFF);
        cfg_write(CFG_OFFSET_Y, 32'hFF80_0000);
        cfg_write(CFG_INV_SQUEEZE_X, 32'h00FF_FFFF);
        cfg_write(CFG_INV_SQUEEZE_Y, 32'h00FF_FFFF);
        cfg_write(CFG_SHEAR_HORIZ, 32'hFFF0_0000);
        cfg_write(CFG_SHEAR_VERT, 32'h000F_FFFF);
        cfg_write(CFG_ROT_COS, 32'h7FFF_FFFF);
        cfg_write(CFG_ROT_SIN, 32'h8000_0000);
        add_point(32767, -32768);
        add_point(0, 0);
        add_point(-32768, 32767);
        add_point(32767, 32767);
        wait_drained();

        // and the other way
        cfg_write(CFG_OFFSET_X, 32'hFF80_0000);
        cfg_write(CFG_OFFSET_Y, 32'h007F_FFFF);
        cfg_write(CFG_SHEAR_HORIZ, 32'h000F_FFFF);
        cfg_write(CFG_SHEAR_VERT, 32'hFFF0_0000);
        cfg_write(CFG_ROT_COS, 32'h8000_0000);
        cfg_write(CFG_ROT_SIN, 32'h7FFF_FFFF);
        add_point(-32768, -32768);
        add_point(1, 1);
        add_point(-1, 0);
        add_point(100, -100);
        wait_drained();

        // random view setups, cycling through four gap/stall profiles
        for (int ph = 0; ph < 8; ph++) begin
            for (int k = 0; k < 8; k++) begin
                wide = ($urandom_range(3) == 0);
                case (t_cfg_idx'(k))
                    CFG_OFFSET_X, CFG_OFFSET_Y:
                        w = wide ? $urandom : ($urandom_range(32767) - 16384);
                    CFG_INV_SQUEEZE_X, CFG_INV_SQUEEZE_Y:
                        w = wide ? $urandom : $urandom_range(98303, 32768);
                    CFG_SHEAR_HORIZ, CFG_SHEAR_VERT:
                        w = wide ? $urandom : ($urandom_range(32767) - 16384);
                    default:
                        w = wide ? $urandom
                                 : ($urandom_range(32'h0FFF_FFFF) - 32'h0800_0000);
                endcase
                cfg_write(t_cfg_idx'(k), w);
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; rcv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rcv_stall_pct = 79; end
                default: begin send_idle_pct = 19; rcv_stall_pct = 19; end
            endcase
            // mostly points near the origin, some over the full range
            for (int n = 0; n < PTS_PER_RUN; n++) begin
                if ($urandom_range(3) == 0)
                    add_point($urandom, $urandom);
                else
                    add_point($urandom_range(4095) - 2048, $urandom_range(4095) - 2048);
            end
            wait_drained();
        end

        send_idle_pct = 0;
        rcv_stall_pct = 0;
        repeat (2 * NSTG) @(posedge i_clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run time limit, far beyond the slowest legal run
    initial begin : watchdog
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
